@@ rtl/stsamp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register codes and constants for the symbol timing sampler.
// No dependencies.
package stsamp_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_PERIOD_DEF  = 32;
    localparam int QUEUE_DEPTH     = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SPP        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULATION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_LVL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LVL    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LVL    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_REF    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_REF    = 3'd7;

    // modulation codes
    localparam logic [1:0] MOD_4FSK = 2'd0;
    localparam logic [1:0] MOD_QPSK = 2'd1;
    localparam logic [1:0] MOD_GFSK = 2'd2;

    // register reset values
    localparam logic [5:0]         RST_SPP        = 6'd10;
    localparam logic [1:0]         RST_MODULATION = MOD_4FSK;
    localparam logic [4:0]         RST_CENTER     = 5'd4;
    localparam logic signed [15:0] RST_CENTER_LVL = 16'sd0;
    localparam logic signed [15:0] RST_MAX_LVL    = 16'sd15000;
    localparam logic signed [15:0] RST_MIN_LVL    = -16'sd15000;
    localparam logic signed [15:0] RST_MAX_REF    = 16'sd12000;
    localparam logic signed [15:0] RST_MIN_REF    = -16'sd12000;

    // timing rules
    localparam int MIN_PERIOD      = 2;
    localparam int PERIOD_LONG     = 20;
    localparam int LONG_WIN_LO     = 7;
    localparam int LONG_WIN_HI     = 13;
    localparam int LONG_REPEAT_LO  = 7;
    localparam int LONG_REPEAT_HI  = 10;
    localparam int LONG_SKIP_LO    = 11;
    localparam int LONG_SKIP_HI    = 14;
    localparam int PERIOD_SHORT    = 5;
    localparam int SHORT_WIN       = 2;
    localparam int QPSK_REPEAT_LIM = 10;

    localparam logic [3:0]  WIN_COUNT_MAX = 4'd15;
    localparam logic [15:0] FLIP_MAX      = 16'hFFFF;
    localparam int EDGE_W  = 6;
    localparam int FLIP_W  = 16;
    localparam int COUNT_W = 4;

    typedef struct packed {
        logic [5:0]         samples_per_symbol;
        logic [1:0]         modulation;
        logic [4:0]         symbol_center;
        logic signed [15:0] center_level;
        logic signed [15:0] max_level;
        logic signed [15:0] min_level;
        logic signed [15:0] max_reference;
        logic signed [15:0] min_reference;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // internal sample width: wide enough for the 16-bit limits too
    function automatic int ext_width(input int sample_bits);
        return (sample_bits > 16) ? sample_bits : 16;
    endfunction

    // window sum holds up to fifteen samples
    function automatic int sum_width(input int sample_bits);
        return ext_width(sample_bits) + 4;
    endfunction

    // queued period word: sum, count, edge, flips
    function automatic int queue_width(input int sample_bits);
        return sum_width(sample_bits) + COUNT_W + EDGE_W + FLIP_W;
    endfunction

endpackage

@@ rtl/stsamp_in_if.sv @@
`timescale 1ns / 1ps
// Sample input channel: valid/ready handshake and one sample word.
// Depends on stsamp_pkg for the default sample width.
interface stsamp_in_if #(
    parameter int SAMPLE_BITS = stsamp_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          in_sync;
    logic                          narrow_left_edge;

    modport source (output valid, sample, in_sync, narrow_left_edge, input ready);
    modport sink   (input valid, sample, in_sync, narrow_left_edge, output ready);
endinterface

@@ rtl/stsamp_out_if.sv @@
`timescale 1ns / 1ps
// Symbol output channel: valid/ready handshake and one symbol word.
// Depends on stsamp_pkg for the default sample width.
interface stsamp_out_if #(
    parameter int SAMPLE_BITS = stsamp_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] symbol_value;
    logic                          empty_window;
    logic signed [5:0]             edge_position;
    logic [15:0]                   flip_count;

    modport source (output valid, symbol_value, empty_window, edge_position, flip_count,
                    input ready);
    modport sink   (input valid, symbol_value, empty_window, edge_position, flip_count,
                    output ready);
endinterface

@@ rtl/stsamp_front.sv @@
`timescale 1ns / 1ps
// Front end: per-sample timing, clamping, crossing count and window integration.
// Depends on stsamp_pkg and stsamp_in_if; pushes one word per period.
module stsamp_front #(
    parameter int SAMPLE_BITS = stsamp_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PERIOD  = stsamp_pkg::MAX_PERIOD_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  stsamp_pkg::t_cfg                             i_cfg,
    stsamp_in_if.sink                                    i_in,
    input  stsamp_pkg::t_queue_status                    i_q_status,
    output logic                                         o_push,
    output logic [stsamp_pkg::queue_width(SAMPLE_BITS)-1:0] o_push_data
);
    import stsamp_pkg::*;

    localparam int EW = ext_width(SAMPLE_BITS);
    localparam int SW = sum_width(SAMPLE_BITS);
    localparam int XW = EW + 4;
    localparam int PW = $clog2(MAX_PERIOD);
    localparam int CW = ((PW > 5) ? PW : 5) + 2;

    logic                 r_open, r_sync, r_edge_valid;
    logic [PW-1:0]        r_position, r_edge_pos;
    logic signed [EW-1:0] r_prev;
    logic [FLIP_W-1:0]    r_crossings;
    logic signed [SW-1:0] r_sum;
    logic [COUNT_W-1:0]   r_count;

    logic signed [CW-1:0] w_spp, w_p, w_c, w_edge, w_move, w_idx, w_edge_fin;
    logic                 w_start, w_sync, w_edge_v0, w_free, w_rec, w_win, w_end;
    logic                 w_accept, w_b1, w_b2;
    logic signed [EW-1:0] w_s0, w_s, w_cl, w_max, w_min;
    logic signed [XW-1:0] w_s4, w_l4, w_hi5, w_lo5;
    logic [FLIP_W:0]      w_cross_sum;
    logic [FLIP_W-1:0]    w_cross_next;
    logic signed [SW-1:0] w_sum_next;
    logic [COUNT_W-1:0]   w_count_next;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_status.full;

    // effective period and centre
    assign w_spp = CW'(signed'({1'b0, i_cfg.samples_per_symbol}));
    assign w_c   = CW'(signed'({1'b0, i_cfg.symbol_center}));
    always_comb begin
        if (w_spp < CW'(MIN_PERIOD)) begin
            w_p = CW'(MIN_PERIOD);
        end else if (w_spp > CW'(MAX_PERIOD)) begin
            w_p = CW'(MAX_PERIOD);
        end else begin
            w_p = w_spp;
        end
    end

    assign w_edge = r_edge_valid ? CW'(signed'({1'b0, r_edge_pos})) : CW'(-1);

    // early/late decision from the edge held over from the last period
    always_comb begin
        w_move = '0;
        if (w_edge >= 0) begin
            if (w_p == CW'(PERIOD_LONG)) begin
                if (w_edge inside {[LONG_REPEAT_LO:LONG_REPEAT_HI]}) begin
                    w_move = CW'(-1);
                end else if (w_edge inside {[LONG_SKIP_LO:LONG_SKIP_HI]}) begin
                    w_move = CW'(1);
                end
            end else begin
                case (i_cfg.modulation)
                    MOD_QPSK: begin
                        if (w_edge < w_c) begin
                            w_move = CW'(1);
                        end else if (w_edge > w_c && w_edge < CW'(QPSK_REPEAT_LIM)) begin
                            w_move = CW'(-1);
                        end
                    end
                    MOD_GFSK: begin
                        if (w_edge >= w_c - 1 && w_edge <= w_c) begin
                            w_move = CW'(-1);
                        end else if (w_edge >= w_c + 1 && w_edge <= w_c + 2) begin
                            w_move = CW'(1);
                        end
                    end
                    MOD_4FSK: begin
                        if (w_edge > 0 && w_edge <= w_c) begin
                            w_move = CW'(-1);
                        end else if (w_edge > w_c && w_edge < w_p) begin
                            w_move = CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign w_start   = !r_open;
    assign w_sync    = w_start ? i_in.in_sync : r_sync;
    assign w_idx     = w_start ? (i_in.in_sync ? '0 : w_move)
                               : CW'(signed'({1'b0, r_position}));
    assign w_edge_v0 = (w_start && !i_in.in_sync) ? 1'b0 : r_edge_valid;

    // clamp in sync with four-level FM; upper test wins
    assign w_s0  = EW'(i_in.sample);
    assign w_cl  = EW'(i_cfg.center_level);
    assign w_max = EW'(i_cfg.max_level);
    assign w_min = EW'(i_cfg.min_level);
    always_comb begin
        w_s = w_s0;
        if (w_sync && i_cfg.modulation == MOD_4FSK) begin
            if (w_s0 > w_max) begin
                w_s = w_max;
            end else if (w_s0 < w_min) begin
                w_s = w_min;
            end
        end
    end

    // 4x > 5y tests for spikes
    assign w_s4  = XW'(w_s) <<< 2;
    assign w_l4  = XW'(r_prev) <<< 2;
    assign w_hi5 = (XW'(i_cfg.max_reference) <<< 2) + XW'(i_cfg.max_reference);
    assign w_lo5 = (XW'(i_cfg.min_reference) <<< 2) + XW'(i_cfg.min_reference);

    assign w_free = !w_edge_v0 && !w_idx[CW-1];

    always_comb begin
        w_b1  = 1'b0;
        w_b2  = 1'b0;
        w_rec = 1'b0;
        if (w_s > w_cl) begin
            w_b1 = r_prev < w_cl;
            if (w_s4 > w_hi5) begin
                w_b2  = w_l4 < w_hi5;
                w_rec = w_free && i_cfg.modulation == MOD_QPSK;
            end else begin
                w_rec = w_free && r_prev < w_cl && i_cfg.modulation != MOD_QPSK;
            end
        end else begin
            w_b1 = r_prev > w_cl;
            if (w_s4 < w_lo5) begin
                w_b2  = w_l4 > w_lo5;
                w_rec = w_free && i_cfg.modulation == MOD_QPSK;
            end else begin
                w_rec = w_free && r_prev > w_cl && i_cfg.modulation != MOD_QPSK;
            end
        end
    end

    assign w_cross_sum  = {1'b0, r_crossings} + (FLIP_W+1)'(w_b1) + (FLIP_W+1)'(w_b2);
    assign w_cross_next = (w_cross_sum > {1'b0, FLIP_MAX}) ? FLIP_MAX
                                                          : w_cross_sum[FLIP_W-1:0];

    // averaging window
    always_comb begin
        if (w_p == CW'(PERIOD_LONG)) begin
            w_win = w_idx inside {[LONG_WIN_LO:LONG_WIN_HI]};
        end else if (w_p == CW'(PERIOD_SHORT)) begin
            w_win = w_idx == CW'(SHORT_WIN);
        end else begin
            case (i_cfg.modulation)
                MOD_4FSK: w_win = w_idx >= w_c - (i_in.narrow_left_edge ? 1 : 2)
                                  && w_idx <= w_c + 2;
                MOD_QPSK: w_win = w_idx == w_c - 1 || w_idx == w_c + 2;
                default:  w_win = w_idx == w_c - 1 || w_idx == w_c + 1;
            endcase
        end
    end

    always_comb begin
        w_sum_next   = r_sum;
        w_count_next = r_count;
        if (w_win && r_count < WIN_COUNT_MAX) begin
            w_sum_next   = r_sum + SW'(w_s);
            w_count_next = r_count + 1'b1;
        end
    end

    assign w_end      = w_idx >= w_p - 1;
    assign w_edge_fin = w_rec ? w_idx : (w_edge_v0 ? CW'(signed'({1'b0, r_edge_pos}))
                                                   : CW'(-1));

    assign o_push      = w_accept && w_end;
    assign o_push_data = {w_sum_next, w_count_next, w_edge_fin[EDGE_W-1:0], w_cross_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_sync       <= 1'b0;
            r_edge_valid <= 1'b0;
            r_edge_pos   <= '0;
            r_position   <= '0;
            r_prev       <= '0;
            r_crossings  <= '0;
            r_sum        <= '0;
            r_count      <= '0;
        end else if (w_accept) begin
            r_prev      <= w_s;
            r_crossings <= w_cross_next;
            if (w_rec) begin
                r_edge_valid <= 1'b1;
                r_edge_pos   <= w_idx[PW-1:0];
            end else begin
                r_edge_valid <= w_edge_v0;
            end
            if (w_end) begin
                r_open     <= 1'b0;
                r_position <= '0;
                r_sum      <= '0;
                r_count    <= '0;
            end else begin
                r_open     <= 1'b1;
                r_sync     <= w_sync;
                r_position <= PW'(w_idx + 1'b1);
                r_sum      <= w_sum_next;
                r_count    <= w_count_next;
            end
        end
    end

endmodule

@@ rtl/stsamp_queue.sv @@
`timescale 1ns / 1ps
// Short register queue between front end and divider back end.
// Depends on stsamp_pkg for the status struct.
module stsamp_queue #(
    parameter int DW    = stsamp_pkg::queue_width(stsamp_pkg::SAMPLE_BITS_DEF),
    parameter int DEPTH = stsamp_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [DW-1:0]             i_data,
    input  logic                      i_pop,
    output logic [DW-1:0]             o_data,
    output stsamp_pkg::t_queue_status o_status
);
    import stsamp_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   r_mem [DEPTH];
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;
    logic            w_push, w_pop;

    assign o_status.full  = r_cnt == CNTW'(DEPTH);
    assign o_status.empty = r_cnt == '0;
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/stsamp_back.sv @@
`timescale 1ns / 1ps
// Back end: serial restoring divider for the window average, output register.
// Depends on stsamp_pkg and stsamp_out_if.
module stsamp_back #(
    parameter int SAMPLE_BITS = stsamp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  stsamp_pkg::t_queue_status                       i_q_status,
    input  logic [stsamp_pkg::queue_width(SAMPLE_BITS)-1:0] i_data,
    output logic                                            o_pop,
    stsamp_out_if.source                                    o_out
);
    import stsamp_pkg::*;

    localparam int SW   = sum_width(SAMPLE_BITS);
    localparam int CNTW = $clog2(SW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]         r_state;
    logic [SW-1:0]      r_quot;
    logic [COUNT_W-1:0] r_div, r_rem;
    logic [CNTW-1:0]    r_cnt;
    logic               r_neg, r_empty;
    logic [EDGE_W-1:0]  r_edge;
    logic [FLIP_W-1:0]  r_flips;

    logic                          r_out_valid, r_out_empty;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic [EDGE_W-1:0]             r_out_edge;
    logic [FLIP_W-1:0]             r_out_flips;

    logic signed [SW-1:0] w_sum;
    logic [COUNT_W-1:0]   w_count;
    logic [COUNT_W:0]     w_trial;
    logic                 w_fit, w_load;
    logic [SW-1:0]        w_val;

    assign w_sum   = signed'(i_data[COUNT_W+EDGE_W+FLIP_W +: SW]);
    assign w_count = i_data[EDGE_W+FLIP_W +: COUNT_W];

    assign o_pop = r_state == ST_IDLE && !i_q_status.empty;

    // one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[SW-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    assign w_val  = r_neg ? -r_quot : r_quot;
    assign w_load = r_state == ST_HOLD && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_edge  <= i_data[FLIP_W +: EDGE_W];
                        r_flips <= i_data[FLIP_W-1:0];
                        r_div   <= w_count;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        if (w_count == '0) begin
                            r_quot  <= '0;
                            r_neg   <= 1'b0;
                            r_empty <= 1'b1;
                            r_state <= ST_HOLD;
                        end else begin
                            r_quot  <= w_sum[SW-1] ? SW'(-w_sum) : SW'(w_sum);
                            r_neg   <= w_sum[SW-1];
                            r_empty <= 1'b0;
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_rem  <= w_fit ? COUNT_W'(w_trial - {1'b0, r_div}) : w_trial[COUNT_W-1:0];
                    r_quot <= {r_quot[SW-2:0], w_fit};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(SW - 1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_val[SAMPLE_BITS-1:0];
            r_out_empty <= r_empty;
            r_out_edge  <= r_edge;
            r_out_flips <= r_flips;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.symbol_value  = r_out_value;
    assign o_out.empty_window  = r_out_empty;
    assign o_out.edge_position = signed'(r_out_edge);
    assign o_out.flip_count    = r_out_flips;

endmodule

@@ rtl/symbol_timing_sampler.sv @@
`timescale 1ns / 1ps
// Top level of the symbol timing sampler: config registers, front end, queue, divider.
// Depends on stsamp_pkg, stsamp_in_if, stsamp_out_if and the stsamp_* modules.
//
// Takes one signed audio sample word per clock on i_sample_if and emits one symbol word
// per symbol period on o_symbol_if. The front end accepts a sample every cycle while the
// period queue has room; it runs the early/late timing adjustment at each period start,
// clamps in sync with four-level FM, counts level crossings (saturating) and integrates
// the samples inside the window around the symbol centre. At the last sample of a period
// the window sum, count, edge mark and crossing count go into a two-entry queue. The back
// end divides the sum by the count with a serial restoring divider, one quotient bit a
// clock over the SW = max(SAMPLE_BITS,16) + 4 bits of the sum; an empty window skips it.
// A period word is divided and passed to the output register before the next is popped.
// Sample rate is one per clock while the divider keeps up; shorter periods fill the queue
// and ready drops until the divider catches up. The result sits in an output register, so
// the divider keeps working while a symbol waits. The configuration write port (index 0..7
// in register order) must be written only while idle; the block does not enforce this.
module symbol_timing_sampler #(
    parameter int SAMPLE_BITS = stsamp_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PERIOD  = stsamp_pkg::MAX_PERIOD_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stsamp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [stsamp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    stsamp_in_if.sink                          i_sample_if,
    stsamp_out_if.source                       o_symbol_if
);
    import stsamp_pkg::*;

    localparam int DW = queue_width(SAMPLE_BITS);

    t_cfg          r_cfg;
    t_queue_status w_q_status;
    logic          w_push, w_pop;
    logic [DW-1:0] w_push_data, w_pop_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_symbol <= RST_SPP;
            r_cfg.modulation         <= RST_MODULATION;
            r_cfg.symbol_center      <= RST_CENTER;
            r_cfg.center_level       <= RST_CENTER_LVL;
            r_cfg.max_level          <= RST_MAX_LVL;
            r_cfg.min_level          <= RST_MIN_LVL;
            r_cfg.max_reference      <= RST_MAX_REF;
            r_cfg.min_reference      <= RST_MIN_REF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SPP:        r_cfg.samples_per_symbol <= i_cfg_data[5:0];
                REG_MODULATION: r_cfg.modulation         <= i_cfg_data[1:0];
                REG_CENTER:     r_cfg.symbol_center      <= i_cfg_data[4:0];
                REG_CENTER_LVL: r_cfg.center_level       <= signed'(i_cfg_data);
                REG_MAX_LVL:    r_cfg.max_level          <= signed'(i_cfg_data);
                REG_MIN_LVL:    r_cfg.min_level          <= signed'(i_cfg_data);
                REG_MAX_REF:    r_cfg.max_reference      <= signed'(i_cfg_data);
                REG_MIN_REF:    r_cfg.min_reference      <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // front end: timing, crossings, integration
    stsamp_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_PERIOD  (MAX_PERIOD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_sample_if),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // period words waiting for the divider
    stsamp_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_data   (w_pop_data),
        .o_status (w_q_status)
    );

    // back end: average and output register
    stsamp_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_data     (w_pop_data),
        .o_pop      (w_pop),
        .o_out      (o_symbol_if)
    );

    // a full queue must hold off the sample stream
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !i_sample_if.ready)
        else $error("sample accepted with period queue full");

    // a period word is only pushed when it can be stored
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("period word pushed into full queue");

    // an empty window always reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_symbol_if.valid && o_symbol_if.empty_window) |-> o_symbol_if.symbol_value == '0)
        else $error("empty window with nonzero symbol");

    // the queue never pops and reports empty at the same time
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("divider popped an empty queue");

endmodule

@@ tb/sv/tb_symbol_timing_sampler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the symbol timing sampler: directed table, then random phases.
// Depends on stsamp_pkg, stsamp_in_if, stsamp_out_if and symbol_timing_sampler.
module tb_symbol_timing_sampler;
    import stsamp_pkg::*;

    // modulation code 3 has no name in the package; like GFSK, with timing moves only at period 20
    localparam logic [1:0] MOD_SPARE = 2'd3;

    localparam int RANDOM_PHASES  = 14;
    localparam int HOLD_PHASE     = 5;
    localparam int HOLD_CYCLES    = 400;  // receiver hold-off, long enough to fill the queue
    localparam int SETTLE_CYCLES  = 64;   // front end plus two queued divides
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 4000; // cycles with no word moving on either side

    typedef struct packed {
        logic signed [15:0] value;
        logic               empty;
        logic signed [5:0]  edge_pos;
        logic [15:0]        flips;
    } t_symbol_word;

    // one row of the directed table: either a register setting or a sample word
    typedef struct {
        bit                 is_setting;
        t_cfg               setting;
        logic signed [15:0] sample;
        bit                 sync_in;
        bit                 narrow;
        bit                 has_sym;
        t_symbol_word       sym;
    } t_step;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stsamp_in_if  sample_ch ();
    stsamp_out_if symbol_ch ();

    symbol_timing_sampler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sample_if (sample_ch),
        .o_symbol_if (symbol_ch)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------------------
    // Predictor: own copy of the registers and of the period state
    // ---------------------------------------------------------------------------------
    t_cfg sampler_cfg = '{
        samples_per_symbol: RST_SPP,        modulation: RST_MODULATION,
        symbol_center:      RST_CENTER,     center_level: RST_CENTER_LVL,
        max_level:          RST_MAX_LVL,    min_level: RST_MIN_LVL,
        max_reference:      RST_MAX_REF,    min_reference: RST_MIN_REF
    };

    int timing_pos   = 0;   // index of the next sample within the period
    int win_sum      = 0;
    int win_count    = 0;
    int last_sample  = 0;
    int edge_mark    = -1;  // first crossing or spike index, -1 when none held
    int flip_total   = 0;
    bit period_open  = 1'b0;
    bit period_sync  = 1'b0;  // in_sync latched at the period's first sample

    t_symbol_word symbols_due[$];
    t_step        directed_steps[$];

    int  error_count     = 0;
    int  samples_taken   = 0;
    int  symbols_checked = 0;
    int  setting_count   = 0;
    int  idle_cycles     = 0;
    bit  idle_on         = 1'b1;
    bit  hold_now        = 1'b0;
    bit           drv_typed = 1'b0;
    t_symbol_word drv_sym   = '0;

    function automatic void count_flip();
        if (flip_total < FLIP_MAX) flip_total++;
    endfunction

    // Advance the period state by one sample word; returns 1 when the word closes a period.
    function automatic bit sampler_advance(input logic signed [15:0] smp, input bit sync_in,
                                           input bit narrow, output t_symbol_word sym);
        int p, c, s, idx, e, last, cl, hi_ref, lo_ref;
        bit in_win;
        p = sampler_cfg.samples_per_symbol;
        if (p < MIN_PERIOD) p = MIN_PERIOD;
        if (p > MAX_PERIOD_DEF) p = MAX_PERIOD_DEF;
        c      = sampler_cfg.symbol_center;
        s      = smp;
        last   = last_sample;
        cl     = $signed(sampler_cfg.center_level);
        hi_ref = 5 * $signed(sampler_cfg.max_reference);
        lo_ref = 5 * $signed(sampler_cfg.min_reference);
        sym    = '0;

        // period start: early/late move when out of sync (repeat gives index -1, skip 1)
        if (!period_open) begin
            period_open = 1'b1;
            period_sync = sync_in;
            idx = 0;
            if (!period_sync) begin
                e = edge_mark;
                if (e >= 0) begin
                    if (p == PERIOD_LONG) begin
                        if (e >= LONG_REPEAT_LO && e <= LONG_REPEAT_HI) idx = -1;
                        else if (e >= LONG_SKIP_LO && e <= LONG_SKIP_HI) idx = 1;
                    end else begin
                        case (sampler_cfg.modulation)
                            MOD_QPSK: begin
                                if (e < c) idx = 1;
                                else if (e > c && e < QPSK_REPEAT_LIM) idx = -1;
                            end
                            MOD_GFSK: begin
                                if (e >= c - 1 && e <= c) idx = -1;
                                else if (e >= c + 1 && e <= c + 2) idx = 1;
                            end
                            MOD_4FSK: begin
                                if (e > 0 && e <= c) idx = -1;
                                else if (e > c && e < p) idx = 1;
                            end
                            default: ;
                        endcase
                    end
                end
                edge_mark = -1;
            end
        end else begin
            idx = timing_pos;
        end

        // clamp in sync with four-level FM; the upper test wins when limits cross
        if (period_sync && sampler_cfg.modulation == MOD_4FSK) begin
            if (s > $signed(sampler_cfg.max_level)) s = $signed(sampler_cfg.max_level);
            else if (s < $signed(sampler_cfg.min_level)) s = $signed(sampler_cfg.min_level);
        end

        // crossings of the centre level and of 1.25x the outer references
        if (s > cl) begin
            if (last < cl) count_flip();
            if (4 * s > hi_ref) begin
                if (4 * last < hi_ref) count_flip();
                if (edge_mark < 0 && idx >= 0 && sampler_cfg.modulation == MOD_QPSK)
                    edge_mark = idx;
            end else if (edge_mark < 0 && idx >= 0 && last < cl &&
                         sampler_cfg.modulation != MOD_QPSK) begin
                edge_mark = idx;
            end
        end else begin
            if (last > cl) count_flip();
            if (4 * s < lo_ref) begin
                if (4 * last > lo_ref) count_flip();
                if (edge_mark < 0 && idx >= 0 && sampler_cfg.modulation == MOD_QPSK)
                    edge_mark = idx;
            end else if (edge_mark < 0 && idx >= 0 && last > cl &&
                         sampler_cfg.modulation != MOD_QPSK) begin
                edge_mark = idx;
            end
        end

        // integrate inside the window around the symbol centre
        if (p == PERIOD_LONG) begin
            in_win = idx >= LONG_WIN_LO && idx <= LONG_WIN_HI;
        end else if (p == PERIOD_SHORT) begin
            in_win = idx == SHORT_WIN;
        end else begin
            case (sampler_cfg.modulation)
                MOD_4FSK: in_win = idx >= c - (narrow ? 1 : 2) && idx <= c + 2;
                MOD_QPSK: in_win = idx == c - 1 || idx == c + 2;
                default:  in_win = idx == c - 1 || idx == c + 1;
            endcase
        end
        if (in_win && win_count < WIN_COUNT_MAX) begin
            win_sum += s;
            win_count++;
        end
        last_sample = s;

        if (idx >= p - 1) begin
            sym.value    = (win_count != 0) ? 16'(win_sum / win_count) : 16'sd0;
            sym.empty    = (win_count == 0);
            sym.edge_pos = 6'(edge_mark);
            sym.flips    = 16'(flip_total);
            win_sum     = 0;
            win_count   = 0;
            timing_pos  = 0;
            period_open = 1'b0;
            return 1'b1;
        end
        timing_pos = idx + 1;
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    function automatic t_cfg pack_setting(input int spp, input int modn, input int ctr,
                                          input int cl, input int maxl, input int minl,
                                          input int maxr, input int minr);
        t_cfg s;
        s.samples_per_symbol = 6'(spp);
        s.modulation         = 2'(modn);
        s.symbol_center      = 5'(ctr);
        s.center_level       = 16'(cl);
        s.max_level          = 16'(maxl);
        s.min_level          = 16'(minl);
        s.max_reference      = 16'(maxr);
        s.min_reference      = 16'(minr);
        return s;
    endfunction

    function automatic void add_setting(input t_cfg s);
        t_step st;
        st = '{default: '0};
        st.is_setting = 1'b1;
        st.setting    = s;
        directed_steps.push_back(st);
    endfunction

    function automatic void add_sample(input int smp, input bit sync_in, input bit narrow);
        t_step st;
        st = '{default: '0};
        st.sample  = 16'(smp);
        st.sync_in = sync_in;
        st.narrow  = narrow;
        directed_steps.push_back(st);
    endfunction

    // sample word that closes a period whose symbol is plain to see
    function automatic void add_checked(input int smp, input bit sync_in, input bit narrow,
                                        input int value, input bit empty, input int edge_at,
                                        input int flips);
        t_step st;
        st = '{default: '0};
        st.sample       = 16'(smp);
        st.sync_in      = sync_in;
        st.narrow       = narrow;
        st.has_sym      = 1'b1;
        st.sym.value    = 16'(value);
        st.sym.empty    = empty;
        st.sym.edge_pos = 6'(edge_at);
        st.sym.flips    = 16'(flips);
        directed_steps.push_back(st);
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // drive one sample word at the falling edge and wait until it is taken
    task automatic push_sample(input logic signed [15:0] smp, input bit sync_in,
                               input bit narrow, input bit has_sym, input t_symbol_word sym);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid            <= 1'b1;
        sample_ch.sample           <= smp;
        sample_ch.in_sync          <= sync_in;
        sample_ch.narrow_left_edge <= narrow;
        drv_typed = has_sym;
        drv_sym   = sym;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // registers change only with nothing outstanding and the back end quiet
    task automatic apply_setting(input t_cfg s);
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SPP,        16'(s.samples_per_symbol));
        write_reg(REG_MODULATION, 16'(s.modulation));
        write_reg(REG_CENTER,     16'(s.symbol_center));
        write_reg(REG_CENTER_LVL, s.center_level);
        write_reg(REG_MAX_LVL,    s.max_level);
        write_reg(REG_MIN_LVL,    s.min_level);
        write_reg(REG_MAX_REF,    s.max_reference);
        write_reg(REG_MIN_REF,    s.min_reference);
        sampler_cfg = s;
        setting_count++;
    endtask

    // ---------------------------------------------------------------------------------
    // Symbol receiver: random stalls, plus one long hold-off counted here
    // ---------------------------------------------------------------------------------
    initial begin : symbol_sink
        int stall;
        stall = 0;
        symbol_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_now) begin
                hold_now = 1'b0;
                symbol_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (stall > 0) begin
                symbol_ch.ready <= 1'b0;
                stall--;
            end else begin
                symbol_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Scoreboard: predict on every sample word taken, compare every symbol word given
    // ---------------------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        t_symbol_word predicted, got, want;
        bit produced, moved;
        moved = 1'b0;
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                moved = 1'b1;
                samples_taken++;
                produced = sampler_advance(sample_ch.sample, sample_ch.in_sync,
                                           sample_ch.narrow_left_edge, predicted);
                if (drv_typed) symbols_due.push_back(drv_sym);
                else if (produced) symbols_due.push_back(predicted);
            end
            if (symbol_ch.valid && symbol_ch.ready) begin
                moved = 1'b1;
                got.value    = symbol_ch.symbol_value;
                got.empty    = symbol_ch.empty_window;
                got.edge_pos = symbol_ch.edge_position;
                got.flips    = symbol_ch.flip_count;
                if (symbols_due.size() == 0) begin
                    $error("symbol word with none expected: value %0d", got.value);
                    error_count++;
                end else begin
                    want = symbols_due.pop_front();
                    symbols_checked++;
                    if (got.value !== want.value) begin
                        $error("symbol_value: expected %0d, got %0d", want.value, got.value);
                        error_count++;
                    end
                    if (got.empty !== want.empty) begin
                        $error("empty_window: expected %0b, got %0b", want.empty, got.empty);
                        error_count++;
                    end
                    if (got.edge_pos !== want.edge_pos) begin
                        $error("edge_position: expected %0d, got %0d",
                               want.edge_pos, got.edge_pos);
                        error_count++;
                    end
                    if (got.flips !== want.flips) begin
                        $error("flip_count: expected %0d, got %0d", want.flips, got.flips);
                        error_count++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("symbol_timing_sampler regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin : main_seq
        t_cfg               s;
        int                 ph, k, n, eff, r, lvl, hold, step, cl, spp, modn, ctr;
        int                 maxl, minl, tmp, sync_style;
        bit                 sync_bit;
        logic signed [15:0] smp;

        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = '0;
        cfg_data                   = '0;
        sample_ch.valid            = 1'b0;
        sample_ch.sample           = '0;
        sample_ch.in_sync          = 1'b0;
        sample_ch.narrow_left_edge = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Period 2, centre 0, in sync: full-scale words clamp to the
        // default level limits and the window holds both words.
        add_setting(pack_setting(2, MOD_4FSK, 0, 0, 15000, -15000, 12000, -12000));
        add_sample(32767, 1'b1, 1'b0);
        add_checked(32767, 1'b1, 1'b0, 15000, 1'b0, -1, 0);
        add_sample(-32768, 1'b1, 1'b1);
        add_checked(-32768, 1'b1, 1'b1, -15000, 1'b0, 0, 1);
        // short period with crossed clamp limits, then out of sync with crossings
        add_setting(pack_setting(PERIOD_SHORT, MOD_4FSK, 2, 100, -200, 300, 32767, -32768));
        add_sample(32767, 1'b1, 1'b0);
        add_sample(-32768, 1'b1, 1'b0);
        add_sample(0, 1'b1, 1'b1);
        add_sample(250, 1'b1, 1'b0);
        add_sample(-1, 1'b1, 1'b0);
        add_sample(-5000, 1'b0, 1'b1);
        add_sample(5000, 1'b0, 1'b0);
        add_sample(-5000, 1'b0, 1'b1);
        add_sample(5000, 1'b0, 1'b0);
        // QPSK with period below the minimum: spikes past 1.25x the references
        add_setting(pack_setting(0, MOD_QPSK, 1, 0, 15000, -15000, 1000, -1000));
        add_sample(2000, 1'b0, 1'b0);
        add_sample(-2000, 1'b0, 1'b1);
        add_sample(0, 1'b0, 1'b0);
        add_sample(1300, 1'b0, 1'b0);
        add_sample(-1300, 1'b0, 1'b1);
        // GFSK, period 3
        add_setting(pack_setting(3, MOD_GFSK, 1, 0, 15000, -15000, 12000, -12000));
        add_sample(-3000, 1'b0, 1'b0);
        add_sample(3000, 1'b0, 1'b1);
        add_sample(3000, 1'b0, 1'b0);
        // spare modulation code, period 1 acting as 2, off-centre midpoint
        add_setting(pack_setting(1, MOD_SPARE, 1, -7, 15000, -15000, 12000, -12000));
        add_sample(32767, 1'b0, 1'b1);
        add_sample(-32768, 1'b0, 1'b0);
        add_sample(-7, 1'b0, 1'b0);
        add_sample(-6, 1'b0, 1'b1);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_setting)
                apply_setting(directed_steps[i].setting);
            else
                push_sample(directed_steps[i].sample, directed_steps[i].sync_in,
                            directed_steps[i].narrow, directed_steps[i].has_sym,
                            directed_steps[i].sym);
        end

        // Random phases: symbol-like level sequences with jittered timing, plus raw noise
        // and extreme words. Partial periods carry across setting changes on purpose.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: s = pack_setting(63, MOD_SPARE, 31, 32767, 32767, 32767, 32767, 32767);
                1: s = pack_setting(0, MOD_4FSK, 0, -32768, -32768, -32768, -32768, -32768);
                HOLD_PHASE: s = pack_setting(2, MOD_4FSK, 1, 0, 15000, -15000, 12000, -12000);
                default: begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0:       spp = PERIOD_LONG;
                        1:       spp = PERIOD_SHORT;
                        2:       spp = $urandom_range(0, 1);
                        3:       spp = $urandom_range(33, 63);
                        4:       spp = MAX_PERIOD_DEF;
                        default: spp = $urandom_range(2, 12);
                    endcase
                    eff  = (spp < MIN_PERIOD) ? MIN_PERIOD :
                           (spp > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : spp;
                    modn = ($urandom_range(0, 7) == 0) ? MOD_SPARE : $urandom_range(0, 2);
                    ctr  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, eff - 1);
                    cl   = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                                       : int'($urandom_range(0, 1000)) - 500;
                    maxl = $urandom_range(6000, 20000);
                    minl = -int'($urandom_range(6000, 20000));
                    if ($urandom_range(0, 5) == 0) begin
                        tmp  = maxl;
                        maxl = minl;
                        minl = tmp;
                    end
                    s = pack_setting(spp, modn, ctr, cl, maxl, minl,
                                     $urandom_range(3000, 14000),
                                     -int'($urandom_range(3000, 14000)));
                end
            endcase
            apply_setting(s);
            idle_on = (ph % 4 != 3) && (ph != HOLD_PHASE);
            if (ph == HOLD_PHASE) hold_now = 1'b1;

            eff = s.samples_per_symbol;
            if (eff < MIN_PERIOD) eff = MIN_PERIOD;
            if (eff > MAX_PERIOD_DEF) eff = MAX_PERIOD_DEF;
            cl         = $signed(s.center_level);
            step       = $urandom_range(1000, 5000);
            sync_style = $urandom_range(0, 2);
            sync_bit   = (sync_style == 1);
            hold       = 0;
            lvl        = 1;
            n          = $urandom_range(110, 160);
            for (k = 0; k < n; k++) begin
                if (hold == 0) begin
                    case ($urandom_range(0, 9))
                        0:       lvl = 5;     // largest level, often past the outer reference
                        1:       lvl = -5;
                        2, 3:    lvl = 3;
                        4, 5:    lvl = -3;
                        6, 7:    lvl = 1;
                        default: lvl = -1;
                    endcase
                    hold = eff + int'($urandom_range(0, 2)) - 1;
                    if (hold < 1) hold = 1;
                end
                hold--;
                if (sync_style == 2 && $urandom_range(0, 7) == 0) sync_bit = ~sync_bit;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    smp = sat16(cl + lvl * step + int'($urandom_range(0, 200)) - 100);
                end else if (r < 90) begin
                    smp = 16'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       smp = 16'sd32767;
                        1:       smp = -16'sd32768;
                        2:       smp = 16'(cl);
                        default: smp = sat16(cl + (($urandom_range(0, 1) == 1) ? 1 : -1));
                    endcase
                end
                push_sample(smp, sync_bit, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        // drain, then let the back end run out before judging
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d sample words and %0d symbol words over %0d register settings",
                 samples_taken, symbols_checked, setting_count);
        $display("including one %0d-cycle receiver hold-off; %0d mismatches",
                 HOLD_CYCLES, error_count);
        if (error_count == 0) begin
            $display("symbol_timing_sampler regression: pass");
        end else begin
            $display("symbol_timing_sampler regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stsamp_pkg.sv
rtl/stsamp_in_if.sv
rtl/stsamp_out_if.sv
rtl/stsamp_front.sv
rtl/stsamp_queue.sv
rtl/stsamp_back.sv
rtl/symbol_timing_sampler.sv
tb/sv/tb_symbol_timing_sampler.sv
